// ===== hw/rtl/aesd_pkg.sv =====
`default_nettype none
package aesd_pkg;

   // field widths of one request word and of a register number
   localparam int unsigned PAGE_OFFSET_W = 12;
   localparam int unsigned WORDS_LEFT_W  = 3;
   localparam int unsigned INSN_W        = 32;
   localparam int unsigned REG_W         = 5;

   // page offsets that can start the sequence
   localparam logic [PAGE_OFFSET_W-1:0] OFFSET_MASK  = 12'hffb;
   localparam logic [PAGE_OFFSET_W-1:0] OFFSET_MATCH = 12'hff8;

   // minimum window lengths for the short and long forms
   localparam logic [WORDS_LEFT_W-1:0] MIN_WORDS_SHORT = 3'd3;
   localparam logic [WORDS_LEFT_W-1:0] MIN_WORDS_LONG  = 3'd4;

   // decoded view of the first stage
   typedef struct packed {
      logic             adrp_ok;
      logic [REG_W-1:0] adrp_rd;
      logic             long_ok;
      logic             mid_qual;
      logic             mid_load;
      logic             mid_wback;
      logic [REG_W-1:0] mid_rt;
      logic [REG_W-1:0] mid_rn;
      logic             w3_uimm;
      logic [REG_W-1:0] w3_rn;
      logic             w3_branch;
      logic             w4_uimm;
      logic [REG_W-1:0] w4_rn;
   } decode_type;

   // match flags of the second stage
   typedef struct packed {
      logic hit_short;
      logic hit_long;
   } match_type;

   function automatic logic m_eq(input logic [INSN_W-1:0] w,
                                 input logic [INSN_W-1:0] mask,
                                 input logic [INSN_W-1:0] val);
      return (w & mask) == val;
   endfunction

   function automatic logic is_adrp(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h9f000000, 32'h90000000);
   endfunction

   function automatic logic is_ldst_class(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h0a000000, 32'h08000000);
   endfunction

   function automatic logic st1m_op(input logic [INSN_W-1:0] w);
      logic [3:0] op;
      op = w[15:12];
      return op == 4'h2 || op == 4'h6 || op == 4'h7 || op == 4'ha;
   endfunction

   function automatic logic st1s_op(input logic [INSN_W-1:0] w);
      logic [INSN_W-1:0] op;
      op = w & 32'h0040e000;
      return op == 32'h0 || op == 32'h4000 || op == 32'h8000;
   endfunction

   function automatic logic is_st1m_post(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'hbfe00000, 32'h0c800000) && st1m_op(w);
   endfunction

   function automatic logic is_st1s_post(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'hbfe00000, 32'h0d800000) && st1s_op(w);
   endfunction

   function automatic logic is_st1_any(input logic [INSN_W-1:0] w);
      return (m_eq(w, 32'hbfff0000, 32'h0c000000) && st1m_op(w)) || is_st1m_post(w) ||
             (m_eq(w, 32'hbfff0000, 32'h0d000000) && st1s_op(w)) || is_st1s_post(w);
   endfunction

   function automatic logic is_literal(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h3b000000, 32'h18000000);
   endfunction

   function automatic logic is_pair_post(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h3bc00000, 32'h28800000);
   endfunction

   function automatic logic is_pair_pre(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h3fc00000, 32'h29800000);
   endfunction

   function automatic logic is_imm_post(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h3b200c00, 32'h38000400);
   endfunction

   function automatic logic is_imm_pre(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h3b200c00, 32'h38000c00);
   endfunction

   function automatic logic is_uimm(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h3b000000, 32'h39000000);
   endfunction

   function automatic logic is_single(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h3b000c00, 32'h38000000) || is_imm_post(w) ||
             m_eq(w, 32'h3b200c00, 32'h38000800) || is_imm_pre(w) ||
             m_eq(w, 32'h3b200c00, 32'h38200800) || is_uimm(w);
   endfunction

   function automatic logic single_is_load(input logic [INSN_W-1:0] w);
      logic [1:0] sz;
      logic       v;
      logic [1:0] opc;
      sz  = w[31:30];
      v   = w[26];
      opc = w[23:22];
      return opc != 2'd0 && !(sz == 2'd0 && v && opc == 2'd2) &&
             !(sz == 2'd3 && !v && opc == 2'd2);
   endfunction

   // second word may sit between the adrp and the final access
   function automatic logic is_mid_qual(input logic [INSN_W-1:0] w);
      return is_ldst_class(w) &&
             (m_eq(w, 32'h3f000000, 32'h08000000) || is_literal(w) || is_single(w) ||
              is_pair_post(w) || m_eq(w, 32'h3bc00000, 32'h29000000) || is_pair_pre(w) ||
              m_eq(w, 32'h3bc00000, 32'h28000000) || is_st1_any(w));
   endfunction

   // load that writes its rt field
   function automatic logic is_v8_load(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'h3f400000, 32'h08400000) || is_literal(w) ||
             (is_single(w) && single_is_load(w));
   endfunction

   // access that writes back its base register
   function automatic logic is_writeback(input logic [INSN_W-1:0] w);
      return is_imm_pre(w) || is_imm_post(w) || is_pair_pre(w) ||
             is_pair_post(w) || is_st1s_post(w) || is_st1m_post(w);
   endfunction

   function automatic logic is_branch(input logic [INSN_W-1:0] w);
      return m_eq(w, 32'hfe000000, 32'h54000000) || m_eq(w, 32'hfe000000, 32'hd6000000) ||
             m_eq(w, 32'h7c000000, 32'h14000000) || m_eq(w, 32'h5c000000, 32'h14000000);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aesd_ifs.sv =====
`default_nettype none
// request channel: one instruction window per word
interface aesd_req_if import aesd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [PAGE_OFFSET_W-1:0] page_offset;
   logic [WORDS_LEFT_W-1:0]  words_left;
   logic [INSN_W-1:0]        first_word;
   logic [INSN_W-1:0]        second_word;
   logic [INSN_W-1:0]        third_word;
   logic [INSN_W-1:0]        fourth_word;

   modport source (output valid, page_offset, words_left, first_word, second_word,
                   third_word, fourth_word, input ready);
   modport sink   (input valid, page_offset, words_left, first_word, second_word,
                   third_word, fourth_word, output ready);
endinterface

// response channel: one verdict per window
interface aesd_rsp_if;
   logic valid;
   logic ready;
   logic detected;
   logic used_optional;

   modport source (output valid, detected, used_optional, input ready);
   modport sink   (input valid, detected, used_optional, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aarch64_erratum_sequence_detector_core.sv =====
// Erratum sequence detector: each request word is a window of four instruction words
// with its page offset and remaining word count; each response word says whether the
// window starts the adrp / load-store / unsigned-immediate access sequence and whether
// the long form (fourth word as final access) was used. One window is accepted per
// cycle while the response side is not stalled; decode, register compare and combine
// each take one register stage. Backpressure stalls only the stages behind a full one,
// so bubbles are squeezed out.
`default_nettype none
module aarch64_erratum_sequence_detector_core
   import aesd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   aesd_req_if.sink    req_chan,
   aesd_rsp_if.source  rsp_chan
);

   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       s3_valid_ff, s3_valid_in;
   logic       s1_ready, s2_ready, s3_ready;
   decode_type s1_ff, s1_in;
   match_type  s2_ff, s2_in;
   logic       det_ff, det_in;
   logic       opt_ff, opt_in;
   logic       mid_ok;

   // stage readiness, back to front
   assign s3_ready = !s3_valid_ff || rsp_chan.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   // stage 1: decode each instruction word
   always_comb begin
      s1_in.adrp_ok   = req_chan.words_left >= MIN_WORDS_SHORT &&
                        (req_chan.page_offset & OFFSET_MASK) == OFFSET_MATCH &&
                        is_adrp(req_chan.first_word);
      s1_in.adrp_rd   = req_chan.first_word[REG_W-1:0];
      s1_in.long_ok   = req_chan.words_left >= MIN_WORDS_LONG;
      s1_in.mid_qual  = is_mid_qual(req_chan.second_word);
      s1_in.mid_load  = is_v8_load(req_chan.second_word);
      s1_in.mid_wback = is_writeback(req_chan.second_word);
      s1_in.mid_rt    = req_chan.second_word[REG_W-1:0];
      s1_in.mid_rn    = req_chan.second_word[REG_W+4:5];
      s1_in.w3_uimm   = is_uimm(req_chan.third_word);
      s1_in.w3_rn     = req_chan.third_word[REG_W+4:5];
      s1_in.w3_branch = is_branch(req_chan.third_word);
      s1_in.w4_uimm   = is_uimm(req_chan.fourth_word);
      s1_in.w4_rn     = req_chan.fourth_word[REG_W+4:5];
      s1_valid_in     = s1_ready ? req_chan.valid : s1_valid_ff;
   end

   // stage 2: register compares against the adrp destination
   always_comb begin
      mid_ok = s1_ff.adrp_ok && s1_ff.mid_qual &&
               !(s1_ff.mid_load && s1_ff.mid_rt == s1_ff.adrp_rd) &&
               !(s1_ff.mid_wback && s1_ff.mid_rn == s1_ff.adrp_rd);
      s2_in.hit_short = mid_ok && s1_ff.w3_uimm && s1_ff.w3_rn == s1_ff.adrp_rd;
      s2_in.hit_long  = mid_ok && s1_ff.long_ok && !s1_ff.w3_branch &&
                        s1_ff.w4_uimm && s1_ff.w4_rn == s1_ff.adrp_rd;
      s2_valid_in     = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   // stage 3: short form wins over long form
   always_comb begin
      det_in      = s2_ff.hit_short || s2_ff.hit_long;
      opt_in      = !s2_ff.hit_short && s2_ff.hit_long;
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // payload registers move only when their stage is free
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         det_ff <= det_in;
         opt_ff <= opt_in;
      end
   end

   assign rsp_chan.valid         = s3_valid_ff;
   assign rsp_chan.detected      = det_ff;
   assign rsp_chan.used_optional = opt_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/aesd_checker.sv =====
`default_nettype none
module aesd_checker (
   input wire clock,
   input wire reset,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_detected,
   input wire rsp_used_optional
);

   // stalled response word stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // stalled response word keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_detected) && $stable(rsp_used_optional))
      else $error("response payload changed while stalled");

   // long form only reported on a detection
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_used_optional |-> rsp_detected)
      else $error("long form flagged without detection");

   // empty output stage means the pipe takes a new word
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output stage");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind aarch64_erratum_sequence_detector_core aesd_checker u_aesd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_detected      (rsp_chan.detected),
   .rsp_used_optional (rsp_chan.used_optional)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// one instruction window as the request channel carries it
typedef struct packed {
   logic [aesd_pkg::PAGE_OFFSET_W-1:0] page_offset;
   logic [aesd_pkg::WORDS_LEFT_W-1:0]  words_left;
   logic [aesd_pkg::INSN_W-1:0]        first_word;
   logic [aesd_pkg::INSN_W-1:0]        second_word;
   logic [aesd_pkg::INSN_W-1:0]        third_word;
   logic [aesd_pkg::INSN_W-1:0]        fourth_word;
} insn_window_type;

// one verdict as the response channel carries it
typedef struct packed {
   logic detected;
   logic used_optional;
} verdict_type;

class sequence_scoreboard;
   localparam int MAX_REPORTS = 10;

   verdict_type pending_verdicts[$];
   int          failures = 0;

   // opcode class decoders
   function bit bits_match(logic [31:0] w, logic [31:0] mask, logic [31:0] val);
      return (w & mask) == val;
   endfunction

   function bit page_addr_op(logic [31:0] w);
      return bits_match(w, 32'h9f000000, 32'h90000000);
   endfunction

   function bit ldst_group(logic [31:0] w);
      return bits_match(w, 32'h0a000000, 32'h08000000);
   endfunction

   function bit vec_multi_op_ok(logic [31:0] w);
      return w[15:12] == 4'h2 || w[15:12] == 4'h6 || w[15:12] == 4'h7 ||
             w[15:12] == 4'ha;
   endfunction

   function bit vec_single_op_ok(logic [31:0] w);
      return !w[22] && !w[13] && !(w[15] && w[14]);
   endfunction

   function bit vec_multi_wb(logic [31:0] w);
      return bits_match(w, 32'hbfe00000, 32'h0c800000) && vec_multi_op_ok(w);
   endfunction

   function bit vec_single_wb(logic [31:0] w);
      return bits_match(w, 32'hbfe00000, 32'h0d800000) && vec_single_op_ok(w);
   endfunction

   function bit vec_store(logic [31:0] w);
      return (bits_match(w, 32'hbfff0000, 32'h0c000000) && vec_multi_op_ok(w)) ||
             vec_multi_wb(w) ||
             (bits_match(w, 32'hbfff0000, 32'h0d000000) && vec_single_op_ok(w)) ||
             vec_single_wb(w);
   endfunction

   function bit literal_load(logic [31:0] w);
      return bits_match(w, 32'h3b000000, 32'h18000000);
   endfunction

   function bit pair_post(logic [31:0] w);
      return bits_match(w, 32'h3bc00000, 32'h28800000);
   endfunction

   function bit pair_pre(logic [31:0] w);
      return bits_match(w, 32'h3fc00000, 32'h29800000);
   endfunction

   function bit imm_post(logic [31:0] w);
      return bits_match(w, 32'h3b200c00, 32'h38000400);
   endfunction

   function bit imm_pre(logic [31:0] w);
      return bits_match(w, 32'h3b200c00, 32'h38000c00);
   endfunction

   function bit uimm_access(logic [31:0] w);
      return bits_match(w, 32'h3b000000, 32'h39000000);
   endfunction

   function bit single_access(logic [31:0] w);
      return bits_match(w, 32'h3b000c00, 32'h38000000) || imm_post(w) ||
             bits_match(w, 32'h3b200c00, 32'h38000800) || imm_pre(w) ||
             bits_match(w, 32'h3b200c00, 32'h38200800) || uimm_access(w);
   endfunction

   // stores of opc 0, prefetch and the simd store forms of opc 2 do not load
   function bit single_loads(logic [31:0] w);
      return w[23:22] != 2'd0 &&
             !(w[31:30] == 2'd0 && w[26] && w[23:22] == 2'd2) &&
             !(w[31:30] == 2'd3 && !w[26] && w[23:22] == 2'd2);
   endfunction

   function bit branch_op(logic [31:0] w);
      return bits_match(w, 32'hfe000000, 32'h54000000) ||
             bits_match(w, 32'hfe000000, 32'hd6000000) ||
             bits_match(w, 32'h7c000000, 32'h14000000) ||
             bits_match(w, 32'h5c000000, 32'h14000000);
   endfunction

   function bit clobbers(logic [31:0] w, logic [4:0] r);
      bit loads_rt;
      bit writes_base;
      loads_rt = bits_match(w, 32'h3f400000, 32'h08400000) || literal_load(w) ||
                 (single_access(w) && single_loads(w));
      writes_base = imm_pre(w) || imm_post(w) || pair_pre(w) || pair_post(w) ||
                    vec_single_wb(w) || vec_multi_wb(w);
      return (loads_rt && w[4:0] == r) || (writes_base && w[9:5] == r);
   endfunction

   // middle access keeps the page base, last access uses it
   function bit chain_ok(logic [4:0] r, logic [31:0] mid, logic [31:0] last);
      bit mid_kind_ok;
      mid_kind_ok = bits_match(mid, 32'h3f000000, 32'h08000000) || literal_load(mid) ||
                    single_access(mid) || pair_post(mid) || pair_pre(mid) ||
                    bits_match(mid, 32'h3bc00000, 32'h29000000) ||
                    bits_match(mid, 32'h3bc00000, 32'h28000000) || vec_store(mid);
      return ldst_group(mid) && mid_kind_ok && !clobbers(mid, r) &&
             uimm_access(last) && last[9:5] == r;
   endfunction

   function verdict_type predict_verdict(insn_window_type w);
      verdict_type v;
      logic [4:0]  base;
      v = '0;
      base = w.first_word[4:0];
      if (w.words_left >= aesd_pkg::MIN_WORDS_SHORT &&
          (w.page_offset & aesd_pkg::OFFSET_MASK) == aesd_pkg::OFFSET_MATCH &&
          page_addr_op(w.first_word)) begin
         // short form wins over the long one
         if (chain_ok(base, w.second_word, w.third_word)) begin
            v.detected = 1'b1;
         end else if (w.words_left >= aesd_pkg::MIN_WORDS_LONG &&
                      !branch_op(w.third_word) &&
                      chain_ok(base, w.second_word, w.fourth_word)) begin
            v.detected      = 1'b1;
            v.used_optional = 1'b1;
         end
      end
      return v;
   endfunction

   function void note_window(insn_window_type w);
      pending_verdicts = {pending_verdicts, predict_verdict(w)};
   endfunction

   function int pending_count();
      return pending_verdicts.size();
   endfunction

   function void check_verdict(verdict_type got);
      verdict_type want;
      if (pending_verdicts.size() == 0) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("unexpected verdict detected=%0b used_optional=%0b",
                     got.detected, got.used_optional);
         return;
      end
      want = pending_verdicts.pop_front();
      if (want.detected !== got.detected || want.used_optional !== got.used_optional) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("verdict mismatch: detected exp %0b got %0b, used_optional exp %0b got %0b",
                     want.detected, got.detected, want.used_optional, got.used_optional);
      end
   endfunction
endclass

module testbench;
   import aesd_pkg::*;

   localparam int CLK_HALF        = 10;
   localparam int RESET_CYCLES    = 5;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int WORDS_PER_PHASE = 210;
   localparam int DRAIN_EVERY     = 150;

   // hand-encoded instructions for the directed windows
   localparam logic [31:0] ADRP_X1        = 32'h90000001;
   localparam logic [31:0] ADR_X1         = 32'h10000001;
   localparam logic [31:0] ADD_IMM        = 32'h91000000;
   localparam logic [31:0] LDR_X2_X3      = 32'hf9400062;
   localparam logic [31:0] LDR_X0_X1      = 32'hf9400020;
   localparam logic [31:0] LDR_X0_X2      = 32'hf9400040;
   localparam logic [31:0] LDR_X1_X3      = 32'hf9400061;
   localparam logic [31:0] LDR_X2_X1_POST = 32'hf8408422;
   localparam logic [31:0] STR_X1_X3      = 32'hf9000061;
   localparam logic [31:0] STP_X1_X3      = 32'ha9000861;
   localparam logic [31:0] LDXR_X1_X3     = 32'hc85f7c61;
   localparam logic [31:0] ST1_X3         = 32'h4c007060;
   localparam logic [31:0] ST1_X1_POST    = 32'h4c9f7020;
   localparam logic [31:0] NOP_WORD       = 32'hd503201f;
   localparam logic [31:0] B_EQ           = 32'h54000000;
   localparam logic [31:0] B_IMM          = 32'h14000000;
   localparam logic [31:0] BR_X0          = 32'hd61f0000;

   // load/store shapes used for the middle word
   typedef enum int {
      MK_EXCL, MK_LITERAL, MK_UNSCALED, MK_POST, MK_UNPRIV, MK_PRE, MK_REGOFF, MK_UIMM,
      MK_PAIR_NT, MK_PAIR_POST, MK_PAIR_OFF, MK_PAIR_PRE,
      MK_ST1M, MK_ST1M_POST, MK_ST1S, MK_ST1S_POST
   } mid_kind_type;

   logic clock = 1'b0;
   logic reset;

   aesd_req_if req_chan ();
   aesd_rsp_if rsp_chan ();

   aarch64_erratum_sequence_detector_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sequence_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int idle_cycles;

   always #(CLK_HALF) clock = ~clock;

   // receiver stalls
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watch both channels
   always @(posedge clock) begin : monitor
      insn_window_type seen;
      verdict_type     got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen.page_offset = req_chan.page_offset;
            seen.words_left  = req_chan.words_left;
            seen.first_word  = req_chan.first_word;
            seen.second_word = req_chan.second_word;
            seen.third_word  = req_chan.third_word;
            seen.fourth_word = req_chan.fourth_word;
            sb.note_window(seen);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.detected      = rsp_chan.detected;
            got.used_optional = rsp_chan.used_optional;
            sb.check_verdict(got);
         end
      end
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] with_template(input logic [31:0] mask,
                                                 input logic [31:0] val);
      return ($urandom() & ~mask) | val;
   endfunction

   function automatic insn_window_type window_of(input logic [11:0] off,
                                                 input logic [2:0] left,
                                                 input logic [31:0] a, input logic [31:0] b,
                                                 input logic [31:0] c, input logic [31:0] d);
      insn_window_type w;
      w.page_offset = off;
      w.words_left  = left;
      w.first_word  = a;
      w.second_word = b;
      w.third_word  = c;
      w.fourth_word = d;
      return w;
   endfunction

   function automatic logic [31:0] make_uimm(input logic [4:0] r);
      logic [31:0] w;
      w = with_template(32'h3b000000, 32'h39000000);
      w[9:5] = r;
      return w;
   endfunction

   function automatic logic [31:0] make_branch();
      case ($urandom_range(3))
         0:       return with_template(32'hfe000000, 32'h54000000);
         1:       return with_template(32'hfe000000, 32'hd6000000);
         2:       return with_template(32'h7c000000, 32'h14000000);
         default: return with_template(32'h5c000000, 32'h14000000);
      endcase
   endfunction

   // random load or store of a chosen shape, often touching the page register
   function automatic logic [31:0] make_mid(input logic [4:0] r);
      logic [31:0]  w;
      mid_kind_type kind;
      kind = mid_kind_type'($urandom_range(15));
      case (kind)
         MK_EXCL:      w = with_template(32'h3f000000, 32'h08000000);
         MK_LITERAL:   w = with_template(32'h3b000000, 32'h18000000);
         MK_UNSCALED:  w = with_template(32'h3b000c00, 32'h38000000);
         MK_POST:      w = with_template(32'h3b200c00, 32'h38000400);
         MK_UNPRIV:    w = with_template(32'h3b200c00, 32'h38000800);
         MK_PRE:       w = with_template(32'h3b200c00, 32'h38000c00);
         MK_REGOFF:    w = with_template(32'h3b200c00, 32'h38200800);
         MK_UIMM:      w = with_template(32'h3b000000, 32'h39000000);
         MK_PAIR_NT:   w = with_template(32'h3bc00000, 32'h28000000);
         MK_PAIR_POST: w = with_template(32'h3bc00000, 32'h28800000);
         MK_PAIR_OFF:  w = with_template(32'h3bc00000, 32'h29000000);
         MK_PAIR_PRE:  w = with_template(32'h3fc00000, 32'h29800000);
         MK_ST1M:      w = with_template(32'hbfff0000, 32'h0c000000);
         MK_ST1M_POST: w = with_template(32'hbfe00000, 32'h0c800000);
         MK_ST1S:      w = with_template(32'hbfff0000, 32'h0d000000);
         default:      w = with_template(32'hbfe00000, 32'h0d800000);
      endcase
      // vector stores need a legal opcode most of the time
      if ((kind == MK_ST1M || kind == MK_ST1M_POST) && $urandom_range(7) != 0) begin
         case ($urandom_range(3))
            0:       w[15:12] = 4'h2;
            1:       w[15:12] = 4'h6;
            2:       w[15:12] = 4'h7;
            default: w[15:12] = 4'ha;
         endcase
      end
      if ((kind == MK_ST1S || kind == MK_ST1S_POST) && $urandom_range(7) != 0) begin
         w[22] = 1'b0;
         case ($urandom_range(2))
            0:       w[15:13] = 3'b000;
            1:       w[15:13] = 3'b010;
            default: w[15:13] = 3'b100;
         endcase
      end
      if ($urandom_range(2) == 0)
         w[4:0] = r;
      if ($urandom_range(2) == 0)
         w[9:5] = r;
      return w;
   endfunction

   // mostly well-formed windows, some broken ones, some noise
   function automatic insn_window_type random_window();
      insn_window_type w;
      logic [4:0]      r;
      int              pick;
      r = 5'($urandom_range(31));
      pick = $urandom_range(99);
      case ($urandom_range(9))
         0:       w.page_offset = 12'($urandom());
         1:       w.page_offset = 12'hff8 | 12'($urandom_range(7));
         default: w.page_offset = $urandom_range(1) ? 12'hffc : 12'hff8;
      endcase
      case ($urandom_range(9))
         0:       w.words_left = 3'($urandom_range(2));
         1:       w.words_left = 3'($urandom_range(7, 5));
         2, 3, 4: w.words_left = 3'd3;
         default: w.words_left = 3'd4;
      endcase
      w.first_word  = with_template(32'h9f000000, 32'h90000000);
      w.first_word[4:0] = r;
      w.second_word = make_mid(r);
      case ($urandom_range(9))
         0, 1, 2, 3: w.third_word = make_uimm(r);
         4, 5:       w.third_word = make_branch();
         6, 7:       w.third_word = make_mid(r);
         8:          w.third_word = make_uimm(5'($urandom_range(31)));
         default:    w.third_word = $urandom();
      endcase
      w.fourth_word = ($urandom_range(9) < 7) ? make_uimm(r) : $urandom();
      if (pick >= 85) begin
         w = window_of(12'($urandom()), 3'($urandom()), $urandom(), $urandom(), $urandom(),
                       $urandom());
      end else if (pick >= 65) begin
         case ($urandom_range(5))
            0:       w.page_offset = 12'($urandom());
            1:       w.words_left  = 3'($urandom());
            2:       w.first_word  = $urandom();
            3:       w.second_word = $urandom();
            4:       w.third_word  = $urandom();
            default: w.fourth_word = $urandom();
         endcase
      end
      return w;
   endfunction

   task automatic send_window(input insn_window_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.page_offset <= w.page_offset;
      req_chan.words_left  <= w.words_left;
      req_chan.first_word  <= w.first_word;
      req_chan.second_word <= w.second_word;
      req_chan.third_word  <= w.third_word;
      req_chan.fourth_word <= w.fourth_word;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // hold off the sender until every verdict is back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0)
         @(posedge clock);
   endtask

   task automatic run_directed();
      // extremes
      send_window(window_of(12'h000, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_window(window_of(12'hfff, 3'd7, '1, '1, '1, '1));
      // short form at both offsets, then offsets that do not qualify
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, LDR_X2_X3, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hffc, 3'd4, ADRP_X1, LDR_X2_X3, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hff4, 3'd3, ADRP_X1, LDR_X2_X3, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hffa, 3'd3, ADRP_X1, LDR_X2_X3, LDR_X0_X1, 32'h0));
      // too few words
      send_window(window_of(12'hff8, 3'd2, ADRP_X1, LDR_X2_X3, LDR_X0_X1, LDR_X0_X1));
      // middle word writes the page register, by load and by writeback
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, LDR_X1_X3, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, LDR_X2_X1_POST, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, LDXR_X1_X3, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, ST1_X1_POST, LDR_X0_X1, 32'h0));
      // stores as middle word
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, STR_X1_X3, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hffc, 3'd3, ADRP_X1, STP_X1_X3, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hffc, 3'd3, ADRP_X1, ST1_X3, LDR_X0_X1, 32'h0));
      // long form, with and without enough words
      send_window(window_of(12'hff8, 3'd4, ADRP_X1, LDR_X2_X3, NOP_WORD, LDR_X0_X1));
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, LDR_X2_X3, NOP_WORD, LDR_X0_X1));
      send_window(window_of(12'hffc, 3'd7, ADRP_X1, LDR_X2_X3, NOP_WORD, LDR_X0_X1));
      // branch as optional middle blocks the long form
      send_window(window_of(12'hff8, 3'd4, ADRP_X1, LDR_X2_X3, B_EQ, LDR_X0_X1));
      send_window(window_of(12'hff8, 3'd4, ADRP_X1, LDR_X2_X3, B_IMM, LDR_X0_X1));
      send_window(window_of(12'hff8, 3'd4, ADRP_X1, LDR_X2_X3, BR_X0, LDR_X0_X1));
      // optional middle that writes the page register still counts
      send_window(window_of(12'hff8, 3'd4, ADRP_X1, LDR_X2_X3, LDR_X1_X3, LDR_X0_X1));
      // both forms match, short one wins
      send_window(window_of(12'hff8, 3'd4, ADRP_X1, LDR_X2_X3, LDR_X0_X1, LDR_X0_X1));
      // wrong first, middle or final word
      send_window(window_of(12'hff8, 3'd3, ADR_X1, LDR_X2_X3, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, ADD_IMM, LDR_X0_X1, 32'h0));
      send_window(window_of(12'hff8, 3'd3, ADRP_X1, LDR_X2_X3, LDR_X0_X2, 32'h0));
   endtask

   initial begin
      sb = new();
      send_idle_pct = 28;
      recv_idle_pct = 84;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.page_offset <= '0;
      req_chan.words_left  <= '0;
      req_chan.first_word  <= '0;
      req_chan.second_word <= '0;
      req_chan.third_word  <= '0;
      req_chan.fourth_word <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain_results();

      // three stall profiles: slow receiver, slow sender, none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 84 : 0;
         recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 28 : 0;
         for (int n = 1; n <= WORDS_PER_PHASE; n++) begin
            send_window(random_window());
            if (n % DRAIN_EVERY == 0)
               drain_results();
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending_count() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== aarch64_erratum_sequence_detector_core.f =====
hw/rtl/aesd_pkg.sv
hw/rtl/aesd_ifs.sv
hw/rtl/aarch64_erratum_sequence_detector_core.sv
hw/rtl/aesd_checker.sv
tb/testbench.sv
